@@ sv/fdhmi_pkg.sv @@
// Package for the floppy drive head, motor and index model.
// Holds the command codes, register indexes and register reset values.
// No dependencies.
package fdhmi_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_STEP   = 3'd1,
    CMD_DIR    = 3'd2,
    CMD_MOTOR  = 3'd3,
    CMD_SEEK   = 3'd4,
    CMD_INSERT = 3'd5,
    CMD_EJECT  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    REG_TRACK_COUNT = 2'd0,
    REG_REV_TICKS   = 2'd1,
    REG_INDEX_TICKS = 2'd2
  } reg_e;

  localparam int unsigned CfgAddrBits = 4;

  localparam logic [7:0]  TrackCountRst = 8'd84;
  localparam logic [23:0] RevTicksRst   = 24'd200000;
  localparam logic [23:0] IndexTicksRst = 24'd2000;

endpackage

@@ sv/floppy_drive_head_motor_index.sv @@
// Drive-side model of a floppy interface: stepper, spindle, index, disk latch.
// Depends on fdhmi_pkg for command codes, register indexes and reset values.
//
// Usage: each input beat on the valid/stall channel carries one command
// (tick, step pin, direction pin, motor pin, direct seek, insert, eject).
// Every accepted beat yields exactly one result beat holding the drive state
// after that command: cylinder, index level and change, ready, track zero,
// disk-change latch, write protect, motor and revolution count.
// The result is registered in the single output register, and one beat is
// taken every cycle unless a held result is stalled by the receiver. While the
// receiver stalls with a result held, the input is stalled and the result
// stays unchanged; a beat is taken in the same cycle the held one leaves.
// The APB port sets track_count, rev_ticks and index_ticks at byte
// addresses 0, 4 and 8, and should be written only while the block is idle.
// Reset puts the head at cylinder 0, motor off, no disk, door latch set,
// and the registers at 84, 200000 and 2000; no result is pending.
module floppy_drive_head_motor_index #(
  parameter int unsigned TIMER_BITS     = 24,
  parameter int unsigned SPINUP_INDEXES = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fdhmi_pkg::CfgAddrBits-1:0]    paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           cmd_i,
  input  logic                                 pin_level_i,
  input  logic [7:0]                           target_cyl_i,
  input  logic [23:0]                          settle_ticks_i,
  input  logic                                 disk_wp_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           cylinder_o,
  output logic                                 index_o,
  output logic                                 index_changed_o,
  output logic                                 ready_res_o,
  output logic                                 track_zero_o,
  output logic                                 disk_changed_o,
  output logic                                 write_protect_o,
  output logic                                 motor_on_o,
  output logic [15:0]                          revolution_count_o
);

  localparam int unsigned CmpW = (TIMER_BITS + 1 > 24) ? TIMER_BITS + 1 : 24;
  localparam int unsigned SpW  = $clog2(SPINUP_INDEXES + 1);
  localparam logic [SpW-1:0] SpinupLoad = SpW'(SPINUP_INDEXES);

  logic [7:0]  track_count_q;
  logic [23:0] rev_ticks_q;
  logic [23:0] index_ticks_q;

  logic [7:0]            head_cyl_q, head_cyl_d;
  logic                  step_level_q, step_level_d;
  logic                  head_dir_q, head_dir_d;
  logic                  motor_q, motor_d;
  logic                  disk_present_q, disk_present_d;
  logic                  protect_q, protect_d;
  logic                  door_latch_q, door_latch_d;
  logic                  index_level_q, index_level_d;
  logic                  ready_q, ready_d;
  logic [SpW-1:0]        spinup_q, spinup_d;
  logic                  spinning_q, spinning_d;
  logic [TIMER_BITS-1:0] phase_q, phase_d;
  logic [15:0]           rev_count_q, rev_count_d;
  logic [TIMER_BITS-1:0] settle_q, settle_d;
  logic                  changed_d;

  logic in_accept;
  logic cfg_write;
  logic [1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      fdhmi_pkg::REG_TRACK_COUNT: prdata = {24'd0, track_count_q};
      fdhmi_pkg::REG_REV_TICKS:   prdata = {8'd0, rev_ticks_q};
      fdhmi_pkg::REG_INDEX_TICKS: prdata = {8'd0, index_ticks_q};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_count_q <= fdhmi_pkg::TrackCountRst;
      rev_ticks_q   <= fdhmi_pkg::RevTicksRst;
      index_ticks_q <= fdhmi_pkg::IndexTicksRst;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        fdhmi_pkg::REG_TRACK_COUNT: track_count_q <= pwdata[7:0];
        fdhmi_pkg::REG_REV_TICKS:   rev_ticks_q   <= pwdata[23:0];
        fdhmi_pkg::REG_INDEX_TICKS: index_ticks_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    logic [CmpW-1:0] phase_inc;
    logic [CmpW-1:0] phase_wrap;
    logic [CmpW-1:0] rev_ext;
    logic [CmpW-1:0] idx_ext;
    logic [CmpW-1:0] phase_ext;
    logic [CmpW-1:0] settle_ext;
    logic            do_eval;
    logic            reload_after;
    logic            lvl;

    head_cyl_d     = head_cyl_q;
    step_level_d   = step_level_q;
    head_dir_d     = head_dir_q;
    motor_d        = motor_q;
    disk_present_d = disk_present_q;
    protect_d      = protect_q;
    door_latch_d   = door_latch_q;
    index_level_d  = index_level_q;
    ready_d        = ready_q;
    spinup_d       = spinup_q;
    spinning_d     = spinning_q;
    phase_d        = phase_q;
    rev_count_d    = rev_count_q;
    settle_d       = settle_q;
    changed_d      = 1'b0;
    do_eval        = 1'b0;
    reload_after   = 1'b0;
    lvl            = 1'b0;

    rev_ext    = CmpW'(rev_ticks_q);
    idx_ext    = CmpW'(index_ticks_q);
    settle_ext = CmpW'(settle_ticks_i);
    phase_inc  = CmpW'(phase_q) + CmpW'(1);
    phase_wrap = CmpW'(phase_inc[TIMER_BITS-1:0]);

    unique case (fdhmi_pkg::cmd_e'(cmd_i))
      fdhmi_pkg::CMD_TICK: begin
        if (settle_q != '0) begin
          settle_d = settle_q - TIMER_BITS'(1);
        end
        if (spinning_q) begin
          if (phase_wrap >= rev_ext || phase_inc >= rev_ext) begin
            phase_d     = '0;
            rev_count_d = rev_count_q + 16'd1;
          end else begin
            phase_d = phase_inc[TIMER_BITS-1:0];
          end
          do_eval = 1'b1;
        end
      end
      fdhmi_pkg::CMD_STEP: begin
        if (pin_level_i != step_level_q) begin
          step_level_d = pin_level_i;
          if (!pin_level_i) begin
            if (head_dir_q) begin
              if (head_cyl_q != 8'd0) begin
                head_cyl_d = head_cyl_q - 8'd1;
              end
            end else if ({1'b0, head_cyl_q} + 9'd1 < {1'b0, track_count_q}) begin
              head_cyl_d = head_cyl_q + 8'd1;
            end
            if (disk_present_q) begin
              door_latch_d = 1'b0;
            end
          end
        end
      end
      fdhmi_pkg::CMD_DIR: begin
        head_dir_d = pin_level_i;
      end
      fdhmi_pkg::CMD_MOTOR: begin
        if (pin_level_i != motor_q) begin
          motor_d = pin_level_i;
          if (pin_level_i) begin
            if (disk_present_q) begin
              spinning_d = 1'b1;
              phase_d    = '0;
              spinup_d   = SpinupLoad;
              do_eval    = 1'b1;
            end
          end else begin
            spinning_d  = 1'b0;
            phase_d     = '0;
            rev_count_d = 16'd0;
            ready_d     = 1'b0;
          end
        end
      end
      fdhmi_pkg::CMD_SEEK: begin
        if (motor_q && target_cyl_i != head_cyl_q) begin
          settle_d = settle_ext[TIMER_BITS-1:0];
          if (target_cyl_i >= track_count_q) begin
            head_cyl_d = (track_count_q != 8'd0) ? track_count_q - 8'd1 : 8'd0;
          end else begin
            head_cyl_d = target_cyl_i;
          end
          if (disk_present_q) begin
            door_latch_d = 1'b0;
          end
        end
      end
      fdhmi_pkg::CMD_INSERT: begin
        if (!disk_present_q) begin
          disk_present_d = 1'b1;
          door_latch_d   = 1'b1;
          protect_d      = disk_wp_i;
          spinning_d     = motor_q;
          phase_d        = '0;
          rev_count_d    = 16'd0;
          do_eval        = 1'b1;
          reload_after   = motor_q;
        end
      end
      fdhmi_pkg::CMD_EJECT: begin
        disk_present_d = 1'b0;
        door_latch_d   = 1'b1;
        protect_d      = 1'b1;
        ready_d        = 1'b0;
      end
      default: ;
    endcase

    phase_ext = CmpW'(phase_d);
    if (do_eval) begin
      if (!spinning_d) begin
        if (index_level_d) begin
          index_level_d = 1'b0;
          changed_d     = 1'b1;
        end
      end else begin
        lvl = phase_ext < idx_ext;
        if (lvl != index_level_d) begin
          index_level_d = lvl;
          changed_d     = 1'b1;
          if (lvl && !ready_d && spinup_d != '0) begin
            spinup_d = spinup_d - SpW'(1);
            if (spinup_d == '0) begin
              ready_d = 1'b1;
            end
          end
        end
      end
    end
    if (reload_after) begin
      spinup_d = SpinupLoad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_cyl_q     <= 8'd0;
      step_level_q   <= 1'b1;
      head_dir_q     <= 1'b0;
      motor_q        <= 1'b0;
      disk_present_q <= 1'b0;
      protect_q      <= 1'b1;
      door_latch_q   <= 1'b1;
      index_level_q  <= 1'b0;
      ready_q        <= 1'b0;
      spinup_q       <= '0;
      spinning_q     <= 1'b0;
      phase_q        <= '0;
      rev_count_q    <= 16'd0;
      settle_q       <= '0;
    end else if (in_accept) begin
      head_cyl_q     <= head_cyl_d;
      step_level_q   <= step_level_d;
      head_dir_q     <= head_dir_d;
      motor_q        <= motor_d;
      disk_present_q <= disk_present_d;
      protect_q      <= protect_d;
      door_latch_q   <= door_latch_d;
      index_level_q  <= index_level_d;
      ready_q        <= ready_d;
      spinup_q       <= spinup_d;
      spinning_q     <= spinning_d;
      phase_q        <= phase_d;
      rev_count_q    <= rev_count_d;
      settle_q       <= settle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_accept) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cylinder_o         <= head_cyl_d;
      index_o            <= index_level_d;
      index_changed_o    <= changed_d;
      ready_res_o        <= ready_d;
      track_zero_o       <= (head_cyl_d == 8'd0) && (settle_d == '0);
      disk_changed_o     <= door_latch_d;
      write_protect_o    <= protect_d;
      motor_on_o         <= motor_d;
      revolution_count_o <= rev_count_d;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    spinning_q |-> motor_q)
    else $error("Spindle turns with the motor off.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && cmd_i == fdhmi_pkg::CMD_EJECT |=> !ready_q && door_latch_q)
    else $error("Eject left the drive ready or the door latch clear.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && track_zero_o |-> cylinder_o == 8'd0)
    else $error("Track zero reported away from cylinder zero.");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for floppy_drive_head_motor_index: a directed command table,
// then random command streams under several register settings, checked by a predictor.
// Depends on fdhmi_pkg and the floppy_drive_head_motor_index top module.
module tb;

  localparam logic [2:0]  CMD_UNUSED = 3'd7;
  localparam logic [1:0]  SpinupLoad = 2'd2;
  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned RandItems  = 924;
  localparam int unsigned NumPhases  = 6;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        pin;
    logic [7:0]  target;
    logic [23:0] settle;
    logic        wp;
  } drive_cmd_t;

  typedef struct packed {
    logic [7:0]  cyl;
    logic        idx;
    logic        idx_chg;
    logic        rdy;
    logic        tz;
    logic        dchg;
    logic        wprot;
    logic        mot;
    logic [15:0] revs;
  } drive_status_t;

  typedef struct packed {
    drive_cmd_t    c;
    logic          known;
    drive_status_t st;
  } plan_row_t;

  localparam drive_status_t IdleStatus =
    {8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0};
  localparam drive_status_t LastCylStatus =
    {8'd83, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0};

  logic                              clk_i   = 1'b0;
  logic                              rst_ni  = 1'b0;
  logic                              psel    = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite  = 1'b0;
  logic [fdhmi_pkg::CfgAddrBits-1:0] paddr   = '0;
  logic [31:0]                       pwdata  = '0;
  logic [31:0]                       prdata;
  logic                              pready;
  logic                              in_valid_i     = 1'b0;
  logic                              in_stall_o;
  logic [2:0]                        cmd_i          = '0;
  logic                              pin_level_i    = 1'b0;
  logic [7:0]                        target_cyl_i   = '0;
  logic [23:0]                       settle_ticks_i = '0;
  logic                              disk_wp_i      = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i    = 1'b0;
  logic [7:0]                        cylinder_o;
  logic                              index_o;
  logic                              index_changed_o;
  logic                              ready_res_o;
  logic                              track_zero_o;
  logic                              disk_changed_o;
  logic                              write_protect_o;
  logic                              motor_on_o;
  logic [15:0]                       revolution_count_o;

  // Predicted drive state and registers, starting at their reset values.
  logic [7:0]  cfg_tracks = fdhmi_pkg::TrackCountRst;
  logic [23:0] cfg_rev    = fdhmi_pkg::RevTicksRst;
  logic [23:0] cfg_idx    = fdhmi_pkg::IndexTicksRst;
  logic [7:0]  hd_cyl     = 8'd0;
  logic        step_lvl   = 1'b1;
  logic        dir_out    = 1'b0;
  logic        motor_pin  = 1'b0;
  logic        disk_in    = 1'b0;
  logic        wp_flag    = 1'b1;
  logic        chg_latch  = 1'b1;
  logic        idx_lvl    = 1'b0;
  logic        rdy        = 1'b0;
  logic [1:0]  spin_left  = 2'd0;
  logic        spin       = 1'b0;
  logic [23:0] phase      = 24'd0;
  logic [15:0] revs       = 16'd0;
  logic [23:0] settle_cnt = 24'd0;

  drive_status_t status_due [$];
  plan_row_t     plan [$];
  drive_status_t seen;
  logic          in_beat   = 1'b0;
  logic          out_beat  = 1'b0;
  logic          apb_ready = 1'b0;
  logic          calm      = 1'b0;
  int unsigned   errors    = 0;
  int unsigned   quiet     = 0;

  floppy_drive_head_motor_index u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .pin_level_i        (pin_level_i),
    .target_cyl_i       (target_cyl_i),
    .settle_ticks_i     (settle_ticks_i),
    .disk_wp_i          (disk_wp_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .cylinder_o         (cylinder_o),
    .index_o            (index_o),
    .index_changed_o    (index_changed_o),
    .ready_res_o        (ready_res_o),
    .track_zero_o       (track_zero_o),
    .disk_changed_o     (disk_changed_o),
    .write_protect_o    (write_protect_o),
    .motor_on_o         (motor_on_o),
    .revolution_count_o (revolution_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Handshakes are sampled at the falling edge, where every signal is settled.
  always @(negedge clk_i) begin
    in_beat   = in_valid_i && !in_stall_o;
    out_beat  = out_valid_o && !out_stall_i;
    apb_ready = pready;
    seen      = {cylinder_o, index_o, index_changed_o, ready_res_o, track_zero_o,
                 disk_changed_o, write_protect_o, motor_on_o, revolution_count_o};
  end

  function automatic logic index_update();
    logic lvl;
    if (!spin) begin
      if (idx_lvl) begin
        idx_lvl = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    end
    lvl = (phase < cfg_idx);
    if (lvl == idx_lvl) return 1'b0;
    idx_lvl = lvl;
    if (lvl && !rdy && spin_left != 2'd0) begin
      spin_left = spin_left - 2'd1;
      if (spin_left == 2'd0) rdy = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic drive_status_t drive_predict(input drive_cmd_t c);
    logic        chg;
    logic [24:0] nxt;
    chg = 1'b0;
    case (c.cmd)
      fdhmi_pkg::CMD_TICK: begin
        if (settle_cnt != 24'd0) settle_cnt = settle_cnt - 24'd1;
        if (spin) begin
          nxt = {1'b0, phase} + 25'd1;
          if (nxt[23:0] >= cfg_rev || nxt >= {1'b0, cfg_rev}) begin
            nxt  = '0;
            revs = revs + 16'd1;
          end
          phase = nxt[23:0];
          chg   = index_update();
        end
      end
      fdhmi_pkg::CMD_STEP: begin
        if (c.pin != step_lvl) begin
          step_lvl = c.pin;
          if (!c.pin) begin
            if (dir_out) begin
              if (hd_cyl != 8'd0) hd_cyl = hd_cyl - 8'd1;
            end else if ({1'b0, hd_cyl} + 9'd1 < {1'b0, cfg_tracks}) begin
              hd_cyl = hd_cyl + 8'd1;
            end
            if (disk_in) chg_latch = 1'b0;
          end
        end
      end
      fdhmi_pkg::CMD_DIR: dir_out = c.pin;
      fdhmi_pkg::CMD_MOTOR: begin
        if (c.pin != motor_pin) begin
          motor_pin = c.pin;
          if (c.pin) begin
            if (disk_in) begin
              spin      = 1'b1;
              phase     = 24'd0;
              spin_left = SpinupLoad;
              chg       = index_update();
            end
          end else begin
            spin  = 1'b0;
            phase = 24'd0;
            revs  = 16'd0;
            rdy   = 1'b0;
          end
        end
      end
      fdhmi_pkg::CMD_SEEK: begin
        if (motor_pin && c.target != hd_cyl) begin
          settle_cnt = c.settle;
          if (c.target >= cfg_tracks) hd_cyl = (cfg_tracks != 8'd0) ? cfg_tracks - 8'd1 : 8'd0;
          else hd_cyl = c.target;
          if (disk_in) chg_latch = 1'b0;
        end
      end
      fdhmi_pkg::CMD_INSERT: begin
        if (!disk_in) begin
          disk_in   = 1'b1;
          chg_latch = 1'b1;
          wp_flag   = c.wp;
          spin      = motor_pin;
          phase     = 24'd0;
          revs      = 16'd0;
          chg       = index_update();
          if (motor_pin) spin_left = SpinupLoad;
        end
      end
      fdhmi_pkg::CMD_EJECT: begin
        disk_in   = 1'b0;
        chg_latch = 1'b1;
        wp_flag   = 1'b1;
        rdy       = 1'b0;
      end
      default: ;
    endcase
    return {hd_cyl, idx_lvl, chg, rdy, (hd_cyl == 8'd0 && settle_cnt == 24'd0),
            chg_latch, wp_flag, motor_pin, revs};
  endfunction

  function automatic void field_check(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : status_check
    drive_status_t due;
    if (rst_ni) out_stall_i <= !calm && ($urandom_range(99) < 31);
    if (out_beat) begin
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, got %h", $time, seen);
      end else begin
        due = status_due.pop_front();
        field_check("cylinder", 16'(due.cyl), 16'(seen.cyl));
        field_check("index", 16'(due.idx), 16'(seen.idx));
        field_check("index_changed", 16'(due.idx_chg), 16'(seen.idx_chg));
        field_check("ready", 16'(due.rdy), 16'(seen.rdy));
        field_check("track_zero", 16'(due.tz), 16'(seen.tz));
        field_check("disk_changed", 16'(due.dchg), 16'(seen.dchg));
        field_check("write_protect", 16'(due.wprot), 16'(seen.wprot));
        field_check("motor_on", 16'(due.mot), 16'(seen.mot));
        field_check("revolution_count", due.revs, seen.revs);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_beat || out_beat) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_cmd(input drive_cmd_t c, input logic known, input drive_status_t st);
    drive_status_t pred;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c.cmd;
    pin_level_i    <= c.pin;
    target_cyl_i   <= c.target;
    settle_ticks_i <= c.settle;
    disk_wp_i      <= c.wp;
    @(posedge clk_i);
    while (!in_beat) @(posedge clk_i);
    pred = drive_predict(c);
    if (known) pred = st;
    status_due = {status_due, pred};
  endtask

  task automatic reg_write(input fdhmi_pkg::reg_e r, input logic [23:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {8'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!apb_ready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (r)
      fdhmi_pkg::REG_TRACK_COUNT: cfg_tracks = v[7:0];
      fdhmi_pkg::REG_REV_TICKS:   cfg_rev = v;
      fdhmi_pkg::REG_INDEX_TICKS: cfg_idx = v;
      default: ;
    endcase
  endtask

  task automatic drain_and_configure(input logic [7:0] t, input logic [23:0] rv,
                                     input logic [23:0] iv);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    reg_write(fdhmi_pkg::REG_TRACK_COUNT, {16'd0, t});
    reg_write(fdhmi_pkg::REG_REV_TICKS, rv);
    reg_write(fdhmi_pkg::REG_INDEX_TICKS, iv);
  endtask

  task automatic plan_row(input logic [2:0] cmd, input logic pin, input logic [7:0] target,
                          input logic [23:0] settle, input logic wp, input logic known,
                          input drive_status_t st);
    plan_row_t row;
    row  = {cmd, pin, target, settle, wp, known, st};
    plan = {plan, row};
  endtask

  function automatic drive_cmd_t pick_cmd();
    drive_cmd_t  c;
    int unsigned roll;
    c.cmd    = fdhmi_pkg::CMD_TICK;
    c.pin    = 1'($urandom_range(1));
    c.target = 8'($urandom_range(255));
    c.settle = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(12));
    c.wp     = 1'($urandom_range(1));
    roll     = $urandom_range(99);
    if (roll < 12) begin
      c.cmd = 3'($urandom_range(7));
    end else if (!disk_in && roll < 22) begin
      c.cmd = fdhmi_pkg::CMD_INSERT;
    end else if (!motor_pin && roll < 32) begin
      c.cmd = fdhmi_pkg::CMD_MOTOR;
      c.pin = 1'b1;
    end else if (roll < 70) begin
      c.cmd = fdhmi_pkg::CMD_TICK;
    end else if (roll < 82) begin
      c.cmd = fdhmi_pkg::CMD_STEP;
      c.pin = !step_lvl;
    end else if (roll < 86) begin
      c.cmd = fdhmi_pkg::CMD_DIR;
    end else if (roll < 92) begin
      c.cmd = fdhmi_pkg::CMD_SEEK;
      if ($urandom_range(1) == 0) c.target = 8'($urandom_range(cfg_tracks));
    end else if (roll < 95) begin
      c.cmd = fdhmi_pkg::CMD_MOTOR;
    end else if (roll < 97) begin
      c.cmd = fdhmi_pkg::CMD_EJECT;
    end else begin
      c.cmd = fdhmi_pkg::CMD_INSERT;
    end
    return c;
  endfunction

  initial begin
    logic [7:0]  t;
    logic [23:0] rv;
    logic [23:0] iv;

    plan_row(CMD_UNUSED,            1'b1, 8'd255, 24'hFFFFFF, 1'b1, 1'b1, IdleStatus);
    plan_row(fdhmi_pkg::CMD_EJECT,  1'b0, 8'd0,   24'd0,      1'b0, 1'b1, IdleStatus);
    plan_row(fdhmi_pkg::CMD_TICK,   1'b0, 8'd0,   24'd0,      1'b0, 1'b1, IdleStatus);
    plan_row(fdhmi_pkg::CMD_STEP,   1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_STEP,   1'b1, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_DIR,    1'b1, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_STEP,   1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_STEP,   1'b1, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_STEP,   1'b0, 8'd0,   24'd0,      1'b0, 1'b1, IdleStatus);
    plan_row(fdhmi_pkg::CMD_SEEK,   1'b0, 8'd200, 24'd5,      1'b0, 1'b1, IdleStatus);
    plan_row(fdhmi_pkg::CMD_MOTOR,  1'b1, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_INSERT, 1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_INSERT, 1'b0, 8'd0,   24'd0,      1'b1, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_SEEK,   1'b0, 8'd255, 24'd3,      1'b0, 1'b1, LastCylStatus);
    plan_row(fdhmi_pkg::CMD_STEP,   1'b1, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_DIR,    1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_STEP,   1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_SEEK,   1'b0, 8'd83,  24'd9,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_TICK,   1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_TICK,   1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_TICK,   1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_SEEK,   1'b0, 8'd0,   24'hFFFFFF, 1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_TICK,   1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_EJECT,  1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_MOTOR,  1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(fdhmi_pkg::CMD_MOTOR,  1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);
    plan_row(CMD_UNUSED,            1'b0, 8'd0,   24'd0,      1'b0, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_cmd(plan[i].c, plan[i].known, plan[i].st);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          t = 8'd255; rv = 24'd2; iv = 24'd1;
        end
        1: begin
          t = 8'd1; rv = 24'hFFFFFF; iv = 24'hFFFFFF;
        end
        2: begin
          t  = 8'($urandom_range(30, 2));
          rv = 24'($urandom_range(40, 3));
          iv = 24'($urandom_range(rv - 1, 1));
        end
        3: begin
          t  = fdhmi_pkg::TrackCountRst;
          rv = 24'($urandom_range(8, 2));
          iv = 24'($urandom_range(20, 1));
        end
        4: begin
          t  = 8'($urandom_range(255, 1));
          rv = 24'($urandom_range(24, 4));
          iv = 24'($urandom_range(3, 1));
        end
        default: begin
          t = 8'd8; rv = 24'd12; iv = 24'd6;
        end
      endcase
      drain_and_configure(t, rv, iv);
      calm = (p == 2);
      for (int n = 0; n < RandItems / NumPhases; n++) send_cmd(pick_cmd(), 1'b0, '0);
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/fdhmi_pkg.sv
sv/floppy_drive_head_motor_index.sv
bench/tb.sv
